[sv/gcbp_pkg.sv]
// Package for the GIF89a block parser: payload structs, event and error codes.
// No dependencies.
package gcbp_pkg;

  localparam int unsigned TableDepthDefault = 256;

  typedef enum logic [2:0] {
    EV_FRAME_START = 3'd0,
    EV_CODE_SIZE   = 3'd1,
    EV_IMAGE_BYTE  = 3'd2,
    EV_FRAME_END   = 3'd3,
    EV_TRAILER     = 3'd4,
    EV_ERROR       = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    ERR_MAGIC      = 4'd0,
    ERR_VERSION    = 4'd1,
    ERR_SIZE       = 4'd2,
    ERR_NO_TABLE   = 4'd3,
    ERR_RESOLUTION = 4'd4,
    ERR_INTERLACE  = 4'd5,
    ERR_LOCAL_TBL  = 4'd6,
    ERR_UNKNOWN    = 4'd7,
    ERR_EARLY_END  = 4'd8
  } error_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  localparam logic [7:0] BlkExtension = 8'h21;
  localparam logic [7:0] BlkImage     = 8'h2C;
  localparam logic [7:0] BlkTrailer   = 8'h3B;
  localparam logic [7:0] LblGfxCtrl   = 8'hF9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] frame_left;
    logic [15:0] frame_top;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic        transparent_on;
    logic [23:0] transparent_rgb;
    logic [7:0]  payload_byte;
    logic [3:0]  error_code;
  } out_t;

  // queued event record
  typedef struct packed {
    event_e      kind;
    logic [7:0]  arg;
    logic [63:0] geo;
    logic        trans_on;
    logic [23:0] rgb;
  } rec_t;

  function automatic logic [7:0] sig_byte(logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h47;
      3'd1:    r = 8'h49;
      3'd2:    r = 8'h46;
      3'd3:    r = 8'h38;
      3'd4:    r = 8'h39;
      default: r = 8'h61;
    endcase
    return r;
  endfunction

endpackage

[sv/gcbp_parser.sv]
// Front end: byte-level parser state machine and global colour table.
// Depends on gcbp_pkg.
module gcbp_parser #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  gcbp_pkg::in_t in_i,
  input  logic [15:0]   exp_w_i,
  input  logic [15:0]   exp_h_i,
  output logic          push_o,
  output gcbp_pkg::rec_t rec_o
);
  import gcbp_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [3:0] {
    PH_HEADER, PH_SCREEN, PH_TABLE, PH_BLOCK, PH_EXT_LABEL, PH_EXT_SIZE,
    PH_EXT_DATA, PH_DESC, PH_CODE, PH_IMG_SIZE, PH_IMG_DATA, PH_DONE, PH_HALT
  } phase_e;

  phase_e      ph_q, ph_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  k3_q, k3_d;
  logic [8:0]  ent_q, ent_d;
  logic [8:0]  nent_q, nent_d;
  logic [7:0]  sub_q, sub_d;
  logic [15:0] rgbp_q, rgbp_d;
  logic        tflag_q, tflag_d;
  logic [7:0]  tslot_q, tslot_d;
  logic [15:0] wd_q [4];
  logic [15:0] wd_d [4];
  logic [7:0]  lbl_q, lbl_d;
  logic        tbl_we;
  logic [23:0] mem [2**AW];
  logic [23:0] rd_q;
  logic [7:0]  b;
  logic        slot_ok;

  assign b = in_i.data_byte;
  assign slot_ok = ({1'b0, tslot_q} < 9'(TABLE_DEPTH));

  always_comb begin
    ph_d = ph_q; cnt_d = cnt_q; k3_d = k3_q; ent_d = ent_q; nent_d = nent_q;
    sub_d = sub_q; rgbp_d = rgbp_q; tflag_d = tflag_q; tslot_d = tslot_q;
    wd_d = wd_q; lbl_d = lbl_q;
    tbl_we = 1'b0;
    push_o = 1'b0;
    rec_o = '0;
    if (acc_i) begin
      case (ph_q)
        PH_HEADER: begin
          if (b != sig_byte(cnt_q[2:0])) begin
            ph_d = PH_HALT; push_o = 1'b1; rec_o.kind = EV_ERROR;
            rec_o.arg = (cnt_q < 4'd3) ? 8'(ERR_MAGIC) : 8'(ERR_VERSION);
          end else if (cnt_q == 4'd5) begin
            ph_d = PH_SCREEN; cnt_d = '0;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        PH_SCREEN: begin
          if (cnt_q < 4'd4) begin
            if (cnt_q[0]) wd_d[cnt_q[2:1]][15:8] = b;
            else wd_d[cnt_q[2:1]] = {8'h00, b};
          end
          if (cnt_q == 4'd4 && (wd_q[0] != exp_w_i || wd_q[1] != exp_h_i)) begin
            ph_d = PH_HALT; push_o = 1'b1; rec_o.kind = EV_ERROR;
            rec_o.arg = 8'(ERR_SIZE);
          end else if (cnt_q == 4'd4 && !b[7]) begin
            ph_d = PH_HALT; push_o = 1'b1; rec_o.kind = EV_ERROR;
            rec_o.arg = 8'(ERR_NO_TABLE);
          end else if (cnt_q == 4'd4 && b[6:4] != 3'd7) begin
            ph_d = PH_HALT; push_o = 1'b1; rec_o.kind = EV_ERROR;
            rec_o.arg = 8'(ERR_RESOLUTION);
          end else begin
            if (cnt_q == 4'd4) nent_d = 9'd2 << b[2:0];
            if (cnt_q == 4'd6) begin
              ph_d = PH_TABLE; cnt_d = '0; k3_d = '0; ent_d = '0; rgbp_d = '0;
            end else begin
              cnt_d = cnt_q + 4'd1;
            end
          end
        end
        PH_TABLE: begin
          if (k3_q == 2'd0) begin
            rgbp_d = {b, 8'h00}; k3_d = 2'd1;
          end else if (k3_q == 2'd1) begin
            rgbp_d = {rgbp_q[15:8], b}; k3_d = 2'd2;
          end else begin
            tbl_we = ent_q < 9'(TABLE_DEPTH);
            k3_d = 2'd0;
            ent_d = ent_q + 9'd1;
            if (ent_q == nent_q - 9'd1) begin
              ph_d = PH_BLOCK; cnt_d = '0;
            end
          end
        end
        PH_BLOCK: begin
          if (b == BlkExtension) ph_d = PH_EXT_LABEL;
          else if (b == BlkImage) begin
            ph_d = PH_DESC; cnt_d = '0;
          end else if (b == BlkTrailer) begin
            ph_d = PH_DONE; push_o = 1'b1; rec_o.kind = EV_TRAILER;
          end else begin
            ph_d = PH_HALT; push_o = 1'b1; rec_o.kind = EV_ERROR;
            rec_o.arg = 8'(ERR_UNKNOWN);
          end
        end
        PH_EXT_LABEL: begin
          lbl_d = b; cnt_d = '0; ph_d = PH_EXT_SIZE;
        end
        PH_EXT_SIZE: begin
          if (b == 8'h00) ph_d = PH_BLOCK;
          else begin
            sub_d = b; ph_d = PH_EXT_DATA;
          end
        end
        PH_EXT_DATA: begin
          if (lbl_q == LblGfxCtrl) begin
            if (cnt_q == 4'd0) tflag_d = b[0];
            else if (cnt_q == 4'd3 && tflag_q) tslot_d = b;
          end
          if (cnt_q != 4'hF) cnt_d = cnt_q + 4'd1;
          if (sub_q <= 8'd1) begin
            sub_d = '0; ph_d = PH_EXT_SIZE;
          end else begin
            sub_d = sub_q - 8'd1;
          end
        end
        PH_DESC: begin
          if (cnt_q < 4'd8) begin
            if (cnt_q[0]) wd_d[cnt_q[2:1]][15:8] = b;
            else wd_d[cnt_q[2:1]] = {8'h00, b};
            cnt_d = cnt_q + 4'd1;
          end else if (b[6]) begin
            ph_d = PH_HALT; push_o = 1'b1; rec_o.kind = EV_ERROR;
            rec_o.arg = 8'(ERR_INTERLACE);
          end else if (b[7]) begin
            ph_d = PH_HALT; push_o = 1'b1; rec_o.kind = EV_ERROR;
            rec_o.arg = 8'(ERR_LOCAL_TBL);
          end else begin
            ph_d = PH_CODE; push_o = 1'b1; rec_o.kind = EV_FRAME_START;
            rec_o.geo = {wd_q[0], wd_q[1], wd_q[2], wd_q[3]};
            rec_o.trans_on = tflag_q;
            rec_o.rgb = (tflag_q && slot_ok) ? rd_q : 24'h0;
          end
        end
        PH_CODE: begin
          ph_d = PH_IMG_SIZE; push_o = 1'b1; rec_o.kind = EV_CODE_SIZE; rec_o.arg = b;
        end
        PH_IMG_SIZE: begin
          if (b == 8'h00) begin
            ph_d = PH_BLOCK; push_o = 1'b1; rec_o.kind = EV_FRAME_END;
          end else begin
            sub_d = b; ph_d = PH_IMG_DATA;
          end
        end
        PH_IMG_DATA: begin
          if (sub_q <= 8'd1) begin
            sub_d = '0; ph_d = PH_IMG_SIZE;
          end else begin
            sub_d = sub_q - 8'd1;
          end
          push_o = 1'b1; rec_o.kind = EV_IMAGE_BYTE; rec_o.arg = b;
        end
        default: ;
      endcase
      if (in_i.end_of_file && ph_q != PH_DONE && ph_q != PH_HALT &&
          ph_d != PH_DONE && ph_d != PH_HALT) begin
        ph_d = PH_HALT; push_o = 1'b1;
        rec_o = '0; rec_o.kind = EV_ERROR; rec_o.arg = 8'(ERR_EARLY_END);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_HEADER; cnt_q <= '0; k3_q <= '0; ent_q <= '0; nent_q <= '0;
      sub_q <= '0; rgbp_q <= '0; tflag_q <= 1'b0; tslot_q <= '0; lbl_q <= '0;
      for (int i = 0; i < 4; i++) wd_q[i] <= '0;
    end else begin
      ph_q <= ph_d; cnt_q <= cnt_d; k3_q <= k3_d; ent_q <= ent_d; nent_q <= nent_d;
      sub_q <= sub_d; rgbp_q <= rgbp_d; tflag_q <= tflag_d; tslot_q <= tslot_d;
      lbl_q <= lbl_d; wd_q <= wd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) mem[ent_q[AW-1:0]] <= {rgbp_q, b};
    rd_q <= mem[tslot_q[AW-1:0]];
  end

endmodule

[sv/gcbp_queue.sv]
// Two-entry event queue between parser and output stage.
// Depends on gcbp_pkg.
module gcbp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gcbp_pkg::rec_t rec_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output gcbp_pkg::rec_t rec_o
);
  import gcbp_pkg::*;

  rec_t       slot_q [2];
  logic [1:0] cnt_q;
  logic       wp_q, rp_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rec_o   = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= rec_i;
  end

endmodule

[sv/gcbp_emit.sv]
// Back end: output register, expands queued records into result fields.
// Depends on gcbp_pkg.
module gcbp_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  gcbp_pkg::rec_t rec_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gcbp_pkg::out_t out_data_o
);
  import gcbp_pkg::*;

  logic ov_q;
  out_t od_q, od_d;

  assign pop_o = q_valid_i && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  always_comb begin
    od_d = '0;
    od_d.event_kind = rec_i.kind;
    case (rec_i.kind)
      EV_FRAME_START: begin
        {od_d.frame_left, od_d.frame_top, od_d.frame_width, od_d.frame_height} = rec_i.geo;
        od_d.transparent_on = rec_i.trans_on;
        od_d.transparent_rgb = rec_i.rgb;
      end
      EV_CODE_SIZE, EV_IMAGE_BYTE: od_d.payload_byte = rec_i.arg;
      EV_ERROR: od_d.error_code = rec_i.arg[3:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (pop_o) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) od_q <= od_d;
  end

endmodule

[sv/gif_container_block_parser.sv]
// GIF89a container block parser: top level, config registers, assertions.
// Depends on gcbp_pkg, gcbp_parser, gcbp_queue, gcbp_emit.
// Throughput: one byte per cycle while the event queue is not full; parser state updates in the accept cycle.
// A result passes through the event queue and then the output register before it appears.
// Input stalls only when the two-entry event queue is full.
// Reset clears all control state; the colour table is not cleared.
module gif_container_block_parser #(
  parameter int unsigned TABLE_DEPTH = gcbp_pkg::TableDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gcbp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gcbp_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [15:0]    cfg_data_i
);
  import gcbp_pkg::*;

  logic [15:0] exp_w_q, exp_h_q;
  logic        acc, push, full, q_valid, pop;
  rec_t        rec_in, rec_out;

  assign in_ready_o = !full;
  assign acc = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_w_q <= 16'd32; exp_h_q <= 16'd16;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_WIDTH) exp_w_q <= cfg_data_i;
      else exp_h_q <= cfg_data_i;
    end
  end

  gcbp_parser #(.TABLE_DEPTH(TABLE_DEPTH)) u_parser (
    .clk_i, .rst_ni, .acc_i(acc), .in_i(in_data_i), .exp_w_i(exp_w_q),
    .exp_h_i(exp_h_q), .push_o(push), .rec_o(rec_in)
  );

  gcbp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .rec_i(rec_in), .full_o(full),
    .valid_o(q_valid), .pop_i(pop), .rec_o(rec_out)
  );

  gcbp_emit u_emit (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .rec_i(rec_out), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push) else $error("push into full queue");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.event_kind <= EV_ERROR) else $error("bad event kind");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_kind != EV_ERROR |-> out_data_o.error_code == '0)
    else $error("error code on non-error event");

endmodule
